FILE: sv/tte_pkg.sv
// Shared types, constants and helper functions for the text terminal unit.
// Used by tte_ctrl and text_terminal_with_escapes_unit; no dependencies.
`default_nettype none
package tte_pkg;

	localparam int DEF_CONSOLES      = 4;
	localparam int DEF_ROWS          = 25;
	localparam int DEF_COLUMNS       = 80;
	localparam int DEF_ESCAPE_BUFFER = 16;
	localparam int DEF_MAX_PARAMS    = 8;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [7:0] CH_BS    = 8'd8;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_ESC   = 8'd27;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] CH_J     = 8'h4A;
	localparam logic [7:0] CH_H     = 8'h48;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_M     = 8'h6D;
	localparam logic [7:0] ATTR_DEF = 8'h07;
	localparam logic [15:0] PARAM_MAX = 16'hFFFF;

	typedef struct packed {
		logic [1:0] op;
		logic [2:0] con;
		logic [7:0] ch;
		logic [4:0] row;
		logic [6:0] col;
	} item_t;

	typedef struct packed {
		logic [7:0] cell_char;
		logic [7:0] cell_attr;
		logic [4:0] pos_row;
		logic [6:0] pos_col;
		logic       status;
	} res_t;

	// cursor position from a 1-based parameter, clamped to the grid
	function automatic logic [6:0] clamp_pos(logic [15:0] p, logic [7:0] lim);
		logic [15:0] v;
		v = (p == 16'd0) ? 16'd0 : p - 16'd1;
		if (v >= 16'(lim))
			return 7'(lim - 8'd1);
		return 7'(v);
	endfunction

	// apply one select-graphic-rendition parameter to a colour
	function automatic logic [7:0] sgr(logic [7:0] c, logic [15:0] p);
		logic [7:0] r;
		r = c;
		if (p == 16'd0)
			r = ATTR_DEF;
		else if (p >= 16'd30 && p <= 16'd37)
			r = {c[7:4], 4'(p - 16'd30)};
		else if (p >= 16'd90 && p <= 16'd97)
			r = {c[7:4], 4'(p - 16'd82)};
		else if (p >= 16'd40 && p <= 16'd47)
			r = {4'(p - 16'd40), c[3:0]};
		else if (p >= 16'd100 && p <= 16'd107)
			r = {4'(p - 16'd92), c[3:0]};
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: sv/text_terminal_with_escapes_unit.sv
// Multi-console text terminal with a small ANSI escape subset.
// Items enter on s_t*: opcode in s_tuser (0 write byte, 1 read cell, 2 clear
// console); console, byte and cell address in s_tdata. Each item gives exactly
// one result on m_t*: cell contents, cursor of that console after the item,
// and a status flag in m_tuser (1 = console number out of range).
// One item is worked on at a time. From acceptance to result:
//   a plain write, control byte or escape byte is executed directly; a read
//   also fetches the cell; a parameter digit that extends a number does a
//   read-modify-write of the parameter memory; a command letter reads each
//   parameter used; a scroll also blanks one row of the cell memory;
//   clear and the erase command blank the whole console, one cell a cycle.
// Scrolling rotates a per-console top-row pointer instead of moving rows.
// After reset the cell memory is swept once while s_tready stays low.
// A result waits in the output register while m_tready is low; the next
// item is still taken, and its result is held until the register frees.
`default_nettype none
module text_terminal_with_escapes_unit import tte_pkg::*; #(
	parameter int CONSOLES      = DEF_CONSOLES,
	parameter int ROWS          = DEF_ROWS,
	parameter int COLUMNS       = DEF_COLUMNS,
	parameter int ESCAPE_BUFFER = DEF_ESCAPE_BUFFER,
	parameter int MAX_PARAMS    = DEF_MAX_PARAMS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// console[2:0], char_code[10:3], cell_row[15:11], cell_col[22:16], zero pad
	input  wire logic [23:0] s_tdata,
	// opcode[1:0]
	input  wire logic [1:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// cell_char[7:0], cell_attr[15:8], pos_row[20:16], pos_col[27:21], zero pad
	output logic [31:0]      m_tdata,
	// status[0]
	output logic             m_tuser
);
	localparam int TOTAL = CONSOLES * ROWS * COLUMNS;
	localparam int CAW   = $clog2(TOTAL);
	localparam int PDEP  = CONSOLES * MAX_PARAMS;
	localparam int PAW   = (PDEP > 1) ? $clog2(PDEP) : 1;

	item_t          item;
	res_t           res;
	logic           res_valid, out_free;
	logic           cw_en, pw_en;
	logic [CAW-1:0] cw_addr, cr_addr;
	logic [PAW-1:0] pw_addr, pr_addr;
	logic [15:0]    cw_data, cr_data, pw_data, pr_data;
	logic           m_tvalid_q;
	logic [31:0]    m_tdata_q;
	logic           m_tuser_q;

	assign item = '{op: s_tuser, con: s_tdata[2:0], ch: s_tdata[10:3],
		row: s_tdata[15:11], col: s_tdata[22:16]};
	assign out_free = !m_tvalid_q || m_tready;

	tte_ctrl #(
		.CONSOLES(CONSOLES), .ROWS(ROWS), .COLUMNS(COLUMNS),
		.ESCAPE_BUFFER(ESCAPE_BUFFER), .MAX_PARAMS(MAX_PARAMS)
	) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready), .in_item(item),
		.out_free(out_free), .res_valid(res_valid), .res(res),
		.cw_en(cw_en), .cw_addr(cw_addr), .cw_data(cw_data),
		.cr_addr(cr_addr), .cr_data(cr_data),
		.pw_en(pw_en), .pw_addr(pw_addr), .pw_data(pw_data),
		.pr_addr(pr_addr), .pr_data(pr_data)
	);

	tte_ram #(.WIDTH(16), .DEPTH(TOTAL)) u_cell_ram (
		.clk(clk), .we(cw_en), .waddr(cw_addr), .wdata(cw_data),
		.raddr(cr_addr), .rdata(cr_data)
	);

	tte_ram #(.WIDTH(16), .DEPTH(PDEP)) u_param_ram (
		.clk(clk), .we(pw_en), .waddr(pw_addr), .wdata(pw_data),
		.raddr(pr_addr), .rdata(pr_data)
	);

	// output register: load a result, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			m_tdata_q <= {4'd0, res.pos_col, res.pos_row, res.cell_attr, res.cell_char};
			m_tuser_q <= res.status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
endmodule
`default_nettype wire

FILE: sv/tte_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module tte_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

FILE: sv/tte_ctrl.sv
// Sequencer of the terminal: per-console cursor and escape state, and the
// cell memory access and parameter read-modify-write. Depends on tte_pkg.
`default_nettype none
module tte_ctrl import tte_pkg::*; #(
	parameter int CONSOLES      = DEF_CONSOLES,
	parameter int ROWS          = DEF_ROWS,
	parameter int COLUMNS       = DEF_COLUMNS,
	parameter int ESCAPE_BUFFER = DEF_ESCAPE_BUFFER,
	parameter int MAX_PARAMS    = DEF_MAX_PARAMS,
	localparam int CELLS = ROWS * COLUMNS,
	localparam int TOTAL = CONSOLES * CELLS,
	localparam int CAW   = $clog2(TOTAL),
	localparam int PDEP  = CONSOLES * MAX_PARAMS,
	localparam int PAW   = (PDEP > 1) ? $clog2(PDEP) : 1
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire item_t          in_item,
	input  wire logic           out_free,
	output logic                res_valid,
	output res_t                res,
	output logic                cw_en,
	output logic [CAW-1:0]      cw_addr,
	output logic [15:0]         cw_data,
	output logic [CAW-1:0]      cr_addr,
	input  wire logic [15:0]    cr_data,
	output logic                pw_en,
	output logic [PAW-1:0]      pw_addr,
	output logic [15:0]         pw_data,
	output logic [PAW-1:0]      pr_addr,
	input  wire logic [15:0]    pr_data
);
	localparam int CW = (CONSOLES > 1) ? $clog2(CONSOLES) : 1;

	typedef enum logic [3:0] {
		ST_INIT, ST_IDLE, ST_EXEC, ST_CRD, ST_SWEEP, ST_PEXT, ST_PRD, ST_PUSE, ST_DONE
	} state_t;
	typedef enum logic [1:0] {CMD_J, CMD_H, CMD_M} cmd_t;

	state_t      state_q;
	item_t       it_q;
	logic [CAW-1:0] init_q;
	logic [4:0]  sw_row_q;
	logic [6:0]  sw_col_q;
	logic        sw_one_q;
	logic [7:0]  fill_q;
	logic [3:0]  pidx_q;
	logic [3:0]  plim_q;
	cmd_t        cmd_q;
	logic [7:0]  cc_q;
	logic [7:0]  ca_q;
	logic        bad_q;

	logic [4:0]  row_q    [CONSOLES];
	logic [6:0]  col_q    [CONSOLES];
	logic [4:0]  top_q    [CONSOLES];
	logic [7:0]  colour_q [CONSOLES];
	logic        esc_q    [CONSOLES];
	logic [4:0]  len_q    [CONSOLES];
	logic [3:0]  cnt_q    [CONSOLES];
	logic        run_q    [CONSOLES];

	function automatic logic [4:0] phys(logic [4:0] r, logic [4:0] t);
		logic [5:0] s;
		s = 6'(r) + 6'(t);
		return (s >= 6'(ROWS)) ? 5'(s - 6'(ROWS)) : 5'(s);
	endfunction

	function automatic logic [CAW-1:0] cell_addr(logic [CW-1:0] k, logic [4:0] r,
			logic [6:0] c);
		return CAW'(k) * CAW'(CELLS) + CAW'(r) * CAW'(COLUMNS) + CAW'(c);
	endfunction

	logic [CW-1:0] cidx;
	logic        con_ok;
	logic [4:0]  cur_row, cur_top, top_next;
	logic [6:0]  cur_col;
	logic [7:0]  cur_colour;
	logic        cur_esc, cur_run;
	logic [4:0]  cur_len;
	logic [3:0]  cur_cnt;
	logic        is_digit, is_letter, acc, printable, wrap, rd_in;
	logic [3:0]  digit;
	logic [PAW-1:0] pbase;
	logic [19:0] ext_v;
	logic        wr_op;

	always_comb begin
		cidx       = it_q.con[CW-1:0];
		con_ok     = {1'b0, it_q.con} < 4'(CONSOLES);
		cur_row    = row_q[cidx];
		cur_col    = col_q[cidx];
		cur_top    = top_q[cidx];
		cur_colour = colour_q[cidx];
		cur_esc    = esc_q[cidx];
		cur_run    = run_q[cidx];
		cur_len    = len_q[cidx];
		cur_cnt    = cnt_q[cidx];
		top_next   = (6'(cur_top) + 6'd1 >= 6'(ROWS)) ? 5'd0 : cur_top + 5'd1;
		is_digit   = it_q.ch >= CH_ZERO && it_q.ch <= CH_NINE;
		is_letter  = (it_q.ch >= CH_UA && it_q.ch <= CH_UZ) ||
			(it_q.ch >= CH_LA && it_q.ch <= CH_LZ);
		digit      = 4'(it_q.ch - CH_ZERO);
		acc        = cur_len < 5'(ESCAPE_BUFFER - 1);
		printable  = it_q.ch != CH_ESC && it_q.ch != CH_LF && it_q.ch != CH_CR &&
			it_q.ch != CH_BS;
		wrap       = it_q.ch == CH_LF ||
			(printable && (8'(cur_col) + 8'd1 >= 8'(COLUMNS)));
		rd_in      = (6'(it_q.row) < 6'(ROWS)) && (8'(it_q.col) < 8'(COLUMNS));
		pbase      = PAW'(cidx) * PAW'(MAX_PARAMS);
		wr_op      = state_q == ST_EXEC && con_ok && it_q.op == OP_WRITE;
		ext_v      = 20'(pr_data) * 20'd10 + 20'(digit);

		cw_en   = 1'b0;
		cw_addr = cell_addr(cidx, phys(cur_row, cur_top), cur_col);
		cw_data = {cur_colour, it_q.ch};
		if (state_q == ST_INIT) begin
			cw_en   = 1'b1;
			cw_addr = init_q;
			cw_data = {ATTR_DEF, CH_SPACE};
		end else if (state_q == ST_SWEEP) begin
			cw_en   = 1'b1;
			cw_addr = cell_addr(cidx, sw_row_q, sw_col_q);
			cw_data = {fill_q, CH_SPACE};
		end else if (wr_op && !cur_esc && printable) begin
			cw_en = 1'b1;
		end
		cr_addr = cell_addr(cidx, phys(it_q.row, cur_top), it_q.col);

		pr_addr = (state_q == ST_PRD) ? pbase + PAW'(pidx_q) : pbase + PAW'(cur_cnt - 4'd1);
		pw_en   = 1'b0;
		pw_addr = pbase + PAW'(cur_cnt);
		pw_data = 16'(digit);
		if (wr_op && cur_esc && acc && is_digit && !(cur_run && cur_cnt != 4'd0) &&
				cur_cnt < 4'(MAX_PARAMS)) begin
			pw_en = 1'b1;
		end else if (state_q == ST_PEXT) begin
			pw_en   = 1'b1;
			pw_addr = pbase + PAW'(cur_cnt - 4'd1);
			pw_data = (ext_v > 20'(PARAM_MAX)) ? PARAM_MAX : 16'(ext_v);
		end

		in_ready  = state_q == ST_IDLE;
		res_valid = state_q == ST_DONE && out_free;
		if (bad_q)
			res = '{cell_char: 8'd0, cell_attr: 8'd0, pos_row: 5'd0, pos_col: 7'd0,
				status: 1'b1};
		else
			res = '{cell_char: cc_q, cell_attr: ca_q, pos_row: cur_row,
				pos_col: cur_col, status: 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_INIT;
			init_q   <= '0;
			sw_row_q <= '0;
			sw_col_q <= '0;
			sw_one_q <= 1'b0;
			pidx_q   <= '0;
			plim_q   <= '0;
			cmd_q    <= CMD_J;
			bad_q    <= 1'b0;
			for (int i = 0; i < CONSOLES; i++) begin
				row_q[i]    <= '0;
				col_q[i]    <= '0;
				top_q[i]    <= '0;
				colour_q[i] <= ATTR_DEF;
				esc_q[i]    <= 1'b0;
				len_q[i]    <= '0;
				cnt_q[i]    <= '0;
				run_q[i]    <= 1'b0;
			end
		end else begin
			case (state_q)
				ST_INIT: begin
					init_q <= init_q + CAW'(1);
					if (init_q == CAW'(TOTAL - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid) begin
						it_q    <= in_item;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					bad_q   <= !con_ok;
					cc_q    <= 8'd0;
					ca_q    <= 8'd0;
					state_q <= ST_DONE;
					if (con_ok) begin
						case (it_q.op)
							OP_READ: begin
								if (rd_in) begin
									state_q <= ST_CRD;
								end else begin
									cc_q <= CH_SPACE;
									ca_q <= ATTR_DEF;
								end
							end
							OP_CLEAR: begin
								row_q[cidx]    <= '0;
								col_q[cidx]    <= '0;
								top_q[cidx]    <= '0;
								colour_q[cidx] <= ATTR_DEF;
								esc_q[cidx]    <= 1'b0;
								len_q[cidx]    <= '0;
								cnt_q[cidx]    <= '0;
								run_q[cidx]    <= 1'b0;
								sw_row_q       <= '0;
								sw_col_q       <= '0;
								sw_one_q       <= 1'b0;
								fill_q         <= ATTR_DEF;
								state_q        <= ST_SWEEP;
							end
							OP_WRITE: begin
								if (!cur_esc) begin
									if (it_q.ch == CH_ESC) begin
										esc_q[cidx] <= 1'b1;
										len_q[cidx] <= '0;
										cnt_q[cidx] <= '0;
										run_q[cidx] <= 1'b0;
									end else if (it_q.ch == CH_CR) begin
										col_q[cidx] <= '0;
									end else if (it_q.ch == CH_BS) begin
										if (cur_col != 7'd0)
											col_q[cidx] <= cur_col - 7'd1;
									end else if (wrap) begin
										col_q[cidx] <= '0;
										if (6'(cur_row) + 6'd1 >= 6'(ROWS)) begin
											// scroll: rotate the top row and blank it
											row_q[cidx] <= 5'(ROWS - 1);
											top_q[cidx] <= top_next;
											sw_row_q    <= cur_top;
											sw_col_q    <= '0;
											sw_one_q    <= 1'b1;
											fill_q      <= cur_colour;
											state_q     <= ST_SWEEP;
										end else begin
											row_q[cidx] <= cur_row + 5'd1;
										end
									end else begin
										col_q[cidx] <= cur_col + 7'd1;
									end
								end else begin
									if (acc) begin
										len_q[cidx] <= cur_len + 5'd1;
										if (is_digit) begin
											if (cur_run && cur_cnt != 4'd0) begin
												state_q <= ST_PEXT;
											end else if (cur_cnt < 4'(MAX_PARAMS)) begin
												cnt_q[cidx] <= cur_cnt + 4'd1;
												run_q[cidx] <= 1'b1;
											end
										end else begin
											run_q[cidx] <= 1'b0;
										end
									end
									if (is_letter) begin
										esc_q[cidx] <= 1'b0;
										pidx_q      <= '0;
										if (it_q.ch == CH_J) begin
											cmd_q  <= CMD_J;
											plim_q <= 4'd1;
											if (cur_cnt != 4'd0)
												state_q <= ST_PRD;
										end else if (it_q.ch == CH_H || it_q.ch == CH_F) begin
											cmd_q       <= CMD_H;
											row_q[cidx] <= '0;
											col_q[cidx] <= '0;
											plim_q      <= (cur_cnt >= 4'd2) ? 4'd2 : cur_cnt;
											if (cur_cnt != 4'd0)
												state_q <= ST_PRD;
										end else if (it_q.ch == CH_M) begin
											cmd_q  <= CMD_M;
											plim_q <= cur_cnt;
											if (cur_cnt != 4'd0)
												state_q <= ST_PRD;
										end
									end
								end
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_CRD: begin
					cc_q    <= cr_data[7:0];
					ca_q    <= cr_data[15:8];
					state_q <= ST_DONE;
				end
				ST_SWEEP: begin
					if (8'(sw_col_q) == 8'(COLUMNS - 1)) begin
						sw_col_q <= '0;
						if (sw_one_q || 6'(sw_row_q) == 6'(ROWS - 1))
							state_q <= ST_DONE;
						else
							sw_row_q <= sw_row_q + 5'd1;
					end else begin
						sw_col_q <= sw_col_q + 7'd1;
					end
				end
				ST_PEXT: begin
					state_q <= ST_DONE;
				end
				ST_PRD: begin
					state_q <= ST_PUSE;
				end
				ST_PUSE: begin
					state_q <= ST_DONE;
					if (5'(pidx_q) + 5'd1 < 5'(plim_q)) begin
						pidx_q  <= pidx_q + 4'd1;
						state_q <= ST_PRD;
					end
					case (cmd_q)
						CMD_J: begin
							if (pr_data == 16'd2) begin
								row_q[cidx] <= '0;
								col_q[cidx] <= '0;
								top_q[cidx] <= '0;
								sw_row_q    <= '0;
								sw_col_q    <= '0;
								sw_one_q    <= 1'b0;
								fill_q      <= cur_colour;
								state_q     <= ST_SWEEP;
							end
						end
						CMD_H: begin
							if (pidx_q == 4'd0)
								row_q[cidx] <= 5'(clamp_pos(pr_data, 8'(ROWS)));
							else
								col_q[cidx] <= clamp_pos(pr_data, 8'(COLUMNS));
						end
						CMD_M: begin
							colour_q[cidx] <= sgr(cur_colour, pr_data);
						end
						default: begin
							state_q <= ST_DONE;
						end
					endcase
				end
				ST_DONE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire
